>>> design/trp_pkg.sv
// Shared types and constants for the telemetry record packer.
// Used by trp_ctrl, trp_dpath and telemetry_record_packer_core; no dependencies.
`default_nettype none

package trp_pkg;

	// Command codes on the request channel.
	localparam logic CMD_EVENT = 1'b0;
	localparam logic CMD_EOF   = 1'b1;

	// Configuration register indexes (paddr[2]).
	localparam logic REG_HEADER_CODE = 1'b0;
	localparam logic REG_SOURCE_ID   = 1'b1;

	localparam int unsigned HEADER_BYTES = 12;
	localparam int unsigned ELEM_BYTES   = 4;

	localparam logic [7:0] SYNC_BYTE0  = 8'hEB;
	localparam logic [7:0] SYNC_BYTE1  = 8'h90;
	localparam logic [1:0] TIME_MARK   = 2'b01;
	localparam logic [7:0] DISC_BYTE   = 8'hBE;
	localparam logic [7:0] SPARE_BYTE  = 8'hC0;
	localparam logic [7:0] HEADER_CODE_RST = 8'h1F;
	localparam logic [7:0] SOURCE_ID_RST   = 8'h20;

	typedef enum logic [1:0] {
		ELEM_EVENT,
		ELEM_TIME,
		ELEM_DISC,
		ELEM_SPARE
	} elem_sel_t;

	typedef struct packed {
		logic      wr_elem;
		elem_sel_t elem_sel;
		logic      rd_start;
		logic      rd_next;
		logic      load_word;
		logic      load_err;
		logic      end_rec;
		logic      clr_frame;
	} trp_cmd_t;

	typedef struct packed {
		logic full_after;
		logic has_elems;
		logic last_word;
		logic out_free;
	} trp_status_t;

endpackage

`default_nettype wire

>>> design/trp_ctrl.sv
// Sequencer of the telemetry record packer: accepts requests and steps the datapath.
// Depends on trp_pkg for command and status types.
`default_nettype none

module trp_ctrl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire logic                 command,
	input  wire logic [1:0]           time_msbs,
	input  wire trp_pkg::trp_status_t status,
	output trp_pkg::trp_cmd_t         cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ELEM,
		ST_FINISH,
		ST_EMIT_RD,
		ST_SEND,
		ST_ERR
	} state_t;

	state_t     state_q, state_n;
	logic       eof_q, eof_n;
	logic [1:0] left_q, left_n;
	logic       time_bad;

	assign time_bad = |time_msbs;
	assign in_stall = (state_q != ST_IDLE);

	always_comb begin
		state_n = state_q;
		eof_n   = eof_q;
		left_n  = left_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (command == trp_pkg::CMD_EVENT) begin
						cmd.wr_elem  = 1'b1;
						cmd.elem_sel = trp_pkg::ELEM_EVENT;
						eof_n        = 1'b0;
						if (status.full_after) state_n = ST_EMIT_RD;
					end else if (time_bad) begin
						state_n = ST_ERR;
					end else begin
						cmd.wr_elem  = 1'b1;
						cmd.elem_sel = trp_pkg::ELEM_TIME;
						eof_n        = 1'b1;
						left_n       = 2'd2;
						state_n      = status.full_after ? ST_EMIT_RD : ST_ELEM;
					end
				end
			end
			ST_ELEM: begin
				cmd.wr_elem  = 1'b1;
				cmd.elem_sel = (left_q == 2'd2) ? trp_pkg::ELEM_DISC : trp_pkg::ELEM_SPARE;
				left_n       = left_q - 2'd1;
				if (status.full_after) state_n = ST_EMIT_RD;
				else if (left_q == 2'd1) state_n = ST_FINISH;
			end
			ST_FINISH: begin
				// A frame end forces out a record that holds any element.
				if (status.has_elems) begin
					state_n = ST_EMIT_RD;
				end else begin
					cmd.clr_frame = 1'b1;
					eof_n         = 1'b0;
					state_n       = ST_IDLE;
				end
			end
			ST_EMIT_RD: begin
				cmd.rd_start = 1'b1;
				state_n      = ST_SEND;
			end
			ST_SEND: begin
				if (status.out_free) begin
					cmd.load_word = 1'b1;
					if (status.last_word) begin
						cmd.end_rec = 1'b1;
						if (!eof_q) state_n = ST_IDLE;
						else if (left_q != 2'd0) state_n = ST_ELEM;
						else state_n = ST_FINISH;
					end else begin
						cmd.rd_next = 1'b1;
					end
				end
			end
			ST_ERR: begin
				if (status.out_free) begin
					cmd.load_err = 1'b1;
					state_n      = ST_IDLE;
				end
			end
			default: begin
				state_n = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			eof_q   <= 1'b0;
			left_q  <= 2'd0;
		end else begin
			state_q <= state_n;
			eof_q   <= eof_n;
			left_q  <= left_n;
		end
	end

endmodule

`default_nettype wire

>>> design/trp_dpath.sv
// Datapath of the telemetry record packer: record memory, fill and record counters,
// header insertion and the output register. Depends on trp_pkg.
`default_nettype none

module trp_dpath #(
	parameter int RECORD_BYTES = 128
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic [7:0]         header_code,
	input  wire logic [7:0]         source_id,
	input  wire logic [13:0]        pha,
	input  wire logic [7:0]         rawx,
	input  wire logic [7:0]         rawy,
	input  wire logic [29:0]        time_ticks,
	input  wire trp_pkg::trp_cmd_t  cmd,
	output trp_pkg::trp_status_t    status,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic [63:0]             data_word,
	output logic                    last_of_record,
	output logic                    time_error
);

	localparam int RECORD_WORDS = (RECORD_BYTES + 7) / 8;
	localparam int AW           = (RECORD_WORDS > 1) ? $clog2(RECORD_WORDS) : 1;
	localparam int FILL_W       = $clog2(RECORD_BYTES + trp_pkg::ELEM_BYTES);

	localparam logic [FILL_W-1:0] FILL_HDR = FILL_W'(trp_pkg::HEADER_BYTES);
	localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(RECORD_BYTES);

	// Each word is kept as two 32-bit halves; an element always fills one half.
	logic [31:0] mem_hi [RECORD_WORDS];
	logic [31:0] mem_lo [RECORD_WORDS];

	logic [FILL_W-1:0] fill_q;
	logic [7:0]        rec_cnt_q;
	logic [7:0]        frame_cnt_q;
	logic [AW-1:0]     idx_q;
	logic [63:0]       rd_word_q;
	logic              out_valid_q;
	logic [63:0]       data_word_q;
	logic              last_q;
	logic              err_q;

	logic [31:0]       elem;
	logic [AW-1:0]     wr_addr;
	logic [AW-1:0]     rd_addr;
	logic [FILL_W-1:0] used;
	logic [FILL_W-1:0] body_bytes;
	logic [7:0]        count_byte;
	logic [63:0]       word_out;
	logic              out_free;

	always_comb begin
		case (cmd.elem_sel)
			trp_pkg::ELEM_EVENT: elem = {2'b00, pha[13:8], pha[7:0], rawy, rawx};
			trp_pkg::ELEM_TIME:  elem = {trp_pkg::TIME_MARK, time_ticks};
			trp_pkg::ELEM_DISC:  elem = {trp_pkg::DISC_BYTE, 24'h000000};
			trp_pkg::ELEM_SPARE: elem = {trp_pkg::SPARE_BYTE, 24'h000000};
			default:             elem = '0;
		endcase
	end

	assign wr_addr = fill_q[AW+2:3];
	assign rd_addr = cmd.rd_start ? '0 : idx_q + AW'(1);

	always_ff @(posedge clk) begin
		if (cmd.wr_elem) begin
			if (fill_q[2]) mem_lo[wr_addr] <= elem;
			else mem_hi[wr_addr] <= elem;
		end
		if (cmd.rd_start || cmd.rd_next) begin
			rd_word_q <= {mem_hi[rd_addr], mem_lo[rd_addr]};
		end
	end

	assign used       = (fill_q > FILL_MAX) ? FILL_MAX : fill_q;
	assign body_bytes = used - FILL_HDR;
	assign count_byte = 8'(body_bytes >> 1);

	// Bytes at or past the used length read as zero, so stale memory never leaks out.
	always_comb begin
		logic [AW+2:0] pos;
		word_out = '0;
		for (int k = 0; k < 8; k++) begin
			pos = {idx_q, 3'(k)};
			if (FILL_W'(pos) < used) word_out[63-8*k -: 8] = rd_word_q[63-8*k -: 8];
		end
		if (idx_q == AW'(0)) begin
			word_out = {trp_pkg::SYNC_BYTE0, trp_pkg::SYNC_BYTE1, 32'h00000000,
				rec_cnt_q, header_code};
		end else if (idx_q == AW'(1)) begin
			word_out[63:32] = {source_id, count_byte, 8'h00, frame_cnt_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q      <= FILL_HDR;
			rec_cnt_q   <= 8'd0;
			frame_cnt_q <= 8'd0;
			idx_q       <= '0;
		end else begin
			if (cmd.end_rec) fill_q <= FILL_HDR;
			else if (cmd.wr_elem) fill_q <= fill_q + FILL_W'(trp_pkg::ELEM_BYTES);
			if (cmd.end_rec) rec_cnt_q <= rec_cnt_q + 8'd1;
			if (cmd.clr_frame) frame_cnt_q <= 8'd0;
			else if (cmd.end_rec) frame_cnt_q <= frame_cnt_q + 8'd1;
			if (cmd.rd_start || cmd.rd_next) idx_q <= rd_addr;
		end
	end

	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_word || cmd.load_err) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_word) begin
			data_word_q <= word_out;
			last_q      <= (idx_q == AW'(RECORD_WORDS - 1));
			err_q       <= 1'b0;
		end else if (cmd.load_err) begin
			data_word_q <= '0;
			last_q      <= 1'b0;
			err_q       <= 1'b1;
		end
	end

	assign out_valid      = out_valid_q;
	assign data_word      = data_word_q;
	assign last_of_record = last_q;
	assign time_error     = err_q;

	assign status.full_after = ({1'b0, fill_q} + (FILL_W+1)'(trp_pkg::ELEM_BYTES))
		>= (FILL_W+1)'(RECORD_BYTES);
	assign status.has_elems  = fill_q > FILL_HDR;
	assign status.last_word  = (idx_q == AW'(RECORD_WORDS - 1));
	assign status.out_free   = out_free;

	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.load_word || cmd.load_err) |-> out_free)
		else $error("output register loaded while a result is still held");

	a_write_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr_elem |-> (fill_q < FILL_MAX))
		else $error("element written into a full record");

	a_no_write_on_read: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.rd_start || cmd.rd_next) |-> !cmd.wr_elem)
		else $error("record memory written during readout");

	a_fill_restart: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.end_rec |=> (fill_q == FILL_HDR))
		else $error("fill offset not restarted after a record");

endmodule

`default_nettype wire

>>> design/telemetry_record_packer_core.sv
// Top level of the telemetry record packer: configuration registers and the
// sequencer/datapath pair. Depends on trp_pkg, trp_ctrl and trp_dpath.
//
//   channel   direction  handshake            payload
//   request   in         in_valid / in_stall  command, pha, rawx, rawy, time_ticks
//   result    out        out_valid/ out_stall data_word, last_of_record, time_error
//   config    in         APB (psel/penable)   paddr, pwdata -> prdata
//
// A pixel event is written when accepted; in_stall stays low unless it fills the record.
// A record leaves at one word per cycle while out_stall is low, after a first memory read:
// RECORD_BYTES/8 words, rounded up, limited by the single read port of the record memory.
// An end of frame writes time, DISC and spare elements, then forces out a non-empty record.
// Reset leaves no record open; the record memory needs no clearing pass.
// Output stalls hold the result register and, through it, the readout.
`default_nettype none

module telemetry_record_packer_core #(
	parameter int RECORD_BYTES = 128
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        command,
	input  wire logic [13:0] pha,
	input  wire logic [7:0]  rawx,
	input  wire logic [7:0]  rawy,
	input  wire logic [31:0] time_ticks,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [63:0]      data_word,
	output logic             last_of_record,
	output logic             time_error
);

	logic [7:0]           header_code_q;
	logic [7:0]           source_id_q;
	logic                 cfg_wr;
	trp_pkg::trp_cmd_t    cmd;
	trp_pkg::trp_status_t status;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_code_q <= trp_pkg::HEADER_CODE_RST;
			source_id_q   <= trp_pkg::SOURCE_ID_RST;
		end else if (cfg_wr) begin
			case (paddr[2])
				trp_pkg::REG_HEADER_CODE: header_code_q <= pwdata[7:0];
				trp_pkg::REG_SOURCE_ID:   source_id_q   <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			trp_pkg::REG_HEADER_CODE: prdata = {24'h000000, header_code_q};
			trp_pkg::REG_SOURCE_ID:   prdata = {24'h000000, source_id_q};
			default:                  prdata = '0;
		endcase
	end

	trp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.command   (command),
		.time_msbs (time_ticks[31:30]),
		.status    (status),
		.cmd       (cmd)
	);

	trp_dpath #(
		.RECORD_BYTES (RECORD_BYTES)
	) u_dpath (
		.clk            (clk),
		.arst_n         (arst_n),
		.header_code    (header_code_q),
		.source_id      (source_id_q),
		.pha            (pha),
		.rawx           (rawx),
		.rawy           (rawy),
		.time_ticks     (time_ticks[29:0]),
		.cmd            (cmd),
		.status         (status),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.data_word      (data_word),
		.last_of_record (last_of_record),
		.time_error     (time_error)
	);

endmodule

`default_nettype wire

>>> tb/telemetry_record_packer_core_tb.sv
// Self-checking testbench for telemetry_record_packer_core: packs pixel events and
// frame ends into telemetry records and compares each emitted word with a local model.
// Depends on trp_pkg and the telemetry_record_packer_core RTL.
`timescale 1ns / 1ps

module telemetry_record_packer_core_tb;

	localparam int RECORD_BYTES = 128;
	localparam int RECORD_WORDS = (RECORD_BYTES + 7) / 8;
	localparam int HDR_BYTES    = 12;
	localparam logic [31:0] MAX_TICKS = 32'h3FFF_FFFF;
	localparam int SETTLE_CYCLES = 2 * RECORD_WORDS + 16;
	localparam int ITEMS_PER_PHASE = 140;

	typedef struct packed {
		logic [63:0] data;
		logic        last;
		logic        err;
	} word_t;

	typedef struct packed {
		logic        cmd;
		logic [13:0] pulse;
		logic [7:0]  col;
		logic [7:0]  row;
		logic [31:0] ticks;
		int          copies;
		bit          typed;
		word_t       want;
	} stim_row_t;

	localparam word_t TIME_ERR_WORD = '{data: 64'h0, last: 1'b0, err: 1'b1};
	localparam word_t NO_WORD       = '{data: 64'h0, last: 1'b0, err: 1'b0};

	logic        clk = 1'b0;
	logic        arst_n;
	logic        psel, penable, pwrite, pready;
	logic [2:0]  paddr;
	logic [31:0] pwdata, prdata;
	logic        in_valid, in_stall, out_valid, out_stall;
	logic        command;
	logic [13:0] pha;
	logic [7:0]  rawx, rawy;
	logic [31:0] time_ticks;
	logic [63:0] data_word;
	logic        last_of_record, time_error;

	telemetry_record_packer_core #(.RECORD_BYTES(RECORD_BYTES)) dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_stall(in_stall),
		.command(command), .pha(pha), .rawx(rawx), .rawy(rawy), .time_ticks(time_ticks),
		.out_valid(out_valid), .out_stall(out_stall),
		.data_word(data_word), .last_of_record(last_of_record), .time_error(time_error)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Local copy of the packer state and registers.
	logic [63:0] rec_words [RECORD_WORDS];
	int unsigned fill_level;
	logic [7:0]  rec_number, frame_rec_number;
	logic [7:0]  cfg_header_code, cfg_source_id;
	word_t       expected_words [$];

	int mismatch_count = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
		mismatch_count++;
	endtask

	function automatic void put_rec_byte(input int unsigned pos, input logic [7:0] v);
		if (pos < RECORD_BYTES) begin
			rec_words[pos / 8][(7 - pos % 8) * 8 +: 8] = v;
		end
	endfunction

	function automatic void close_record();
		int unsigned used;
		word_t w;
		used = (fill_level > RECORD_BYTES) ? RECORD_BYTES : fill_level;
		put_rec_byte(0, 8'hEB);
		put_rec_byte(1, 8'h90);
		put_rec_byte(2, 8'h00);
		put_rec_byte(3, 8'h00);
		put_rec_byte(4, 8'h00);
		put_rec_byte(5, 8'h00);
		put_rec_byte(6, rec_number);
		put_rec_byte(7, cfg_header_code);
		put_rec_byte(8, cfg_source_id);
		put_rec_byte(9, 8'((used - HDR_BYTES) / 2));
		put_rec_byte(10, 8'h00);
		put_rec_byte(11, frame_rec_number);
		for (int i = 0; i < RECORD_WORDS; i++) begin
			w.data = rec_words[i];
			w.last = (i == RECORD_WORDS - 1);
			w.err  = 1'b0;
			expected_words.push_back(w);
			rec_words[i] = 64'h0;
		end
		rec_number++;
		frame_rec_number++;
		fill_level = HDR_BYTES;
	endfunction

	function automatic void add_element(input logic [7:0] b0, input logic [7:0] b1,
			input logic [7:0] b2, input logic [7:0] b3);
		put_rec_byte(fill_level, b0);
		put_rec_byte(fill_level + 1, b1);
		put_rec_byte(fill_level + 2, b2);
		put_rec_byte(fill_level + 3, b3);
		fill_level += 4;
		if (fill_level >= RECORD_BYTES) begin
			close_record();
		end
	endfunction

	function automatic void pack_request(input stim_row_t r);
		if (r.cmd == trp_pkg::CMD_EVENT) begin
			add_element({2'b00, r.pulse[13:8]}, r.pulse[7:0], r.row, r.col);
		end else if (r.ticks > MAX_TICKS) begin
			// An out-of-range time yields one error word and leaves the record alone.
			expected_words.push_back(TIME_ERR_WORD);
		end else begin
			add_element(8'h40 + r.ticks[31:24], r.ticks[23:16], r.ticks[15:8], r.ticks[7:0]);
			add_element(8'hBE, 8'h00, 8'h00, 8'h00);
			add_element(8'hC0, 8'h00, 8'h00, 8'h00);
			if (fill_level > HDR_BYTES) begin
				close_record();
			end
			frame_rec_number = 8'h00;
		end
	endfunction

	// Called at a falling edge; returns at the falling edge after the request is taken.
	task automatic send_request(input stim_row_t r);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid   = 1'b1;
		command    = r.cmd;
		pha        = r.pulse;
		rawx       = r.col;
		rawy       = r.row;
		time_ticks = r.ticks;
		@(posedge clk);
		while (in_stall) begin
			@(posedge clk);
		end
		if (r.typed) begin
			expected_words.push_back(r.want);
		end else begin
			pack_request(r);
		end
		@(negedge clk);
	endtask

	task automatic apb_write(input logic reg_idx, input logic [7:0] value);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b1;
		paddr   = {reg_idx, 2'b00};
		pwdata  = {24'h0, value};
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		while (!pready) begin
			@(posedge clk);
		end
		if (reg_idx == trp_pkg::REG_HEADER_CODE) begin
			cfg_header_code = value;
		end else begin
			cfg_source_id = value;
		end
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
	endtask

	// Waits until every expected word has come out and the block has gone quiet.
	task automatic settle_block();
		in_valid = 1'b0;
		while (expected_words.size() != 0) begin
			@(negedge clk);
		end
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Mostly complete frames with random content, plus stray events and bad frame times.
	task automatic run_random_frames(input int item_goal, input bit pause_midway);
		int sent;
		int n_events;
		bit paused;
		stim_row_t r;
		sent = 0;
		paused = 1'b0;
		r = '0;
		while (sent < item_goal) begin
			if (pause_midway && !paused && sent >= item_goal / 2) begin
				in_valid = 1'b0;
				while (expected_words.size() != 0) begin
					@(negedge clk);
				end
				paused = 1'b1;
			end
			if ($urandom_range(99) < 85) begin
				n_events = ($urandom_range(9) == 0) ? $urandom_range(70, 30)
					: $urandom_range(28, 0);
				for (int k = 0; k < n_events; k++) begin
					r.cmd   = trp_pkg::CMD_EVENT;
					r.pulse = 14'($urandom);
					r.col   = 8'($urandom);
					r.row   = 8'($urandom);
					r.ticks = $urandom;
					send_request(r);
				end
				r.cmd = trp_pkg::CMD_EOF;
				if ($urandom_range(9) == 0) begin
					r.ticks = $urandom_range(32'hFFFF_FFFF, MAX_TICKS + 1);
					send_request(r);
					sent++;
				end
				case ($urandom_range(9))
					0: r.ticks = 32'h0;
					1: r.ticks = MAX_TICKS;
					default: r.ticks = $urandom_range(MAX_TICKS, 0);
				endcase
				send_request(r);
				sent += n_events + 1;
			end else begin
				r.cmd   = ($urandom_range(1) == 0) ? trp_pkg::CMD_EVENT : trp_pkg::CMD_EOF;
				r.pulse = 14'($urandom);
				r.col   = 8'($urandom);
				r.row   = 8'($urandom);
				r.ticks = $urandom_range(32'hFFFF_FFFF, MAX_TICKS + 1);
				send_request(r);
				sent++;
			end
		end
	endtask

	// Error rows carry their expected word; the rest go through the local model.
	stim_row_t dir_rows [15] = '{
		'{trp_pkg::CMD_EOF,   14'h0000, 8'h00, 8'h00, 32'h0000_0000,  1, 1'b0, NO_WORD},
		'{trp_pkg::CMD_EOF,   14'h0000, 8'h00, 8'h00, 32'h3FFF_FFFF,  1, 1'b0, NO_WORD},
		'{trp_pkg::CMD_EOF,   14'h0000, 8'h00, 8'h00, 32'h4000_0000,  1, 1'b1, TIME_ERR_WORD},
		'{trp_pkg::CMD_EOF,   14'h3FFF, 8'hFF, 8'hFF, 32'hFFFF_FFFF,  1, 1'b1, TIME_ERR_WORD},
		'{trp_pkg::CMD_EVENT, 14'h0000, 8'h00, 8'h00, 32'h0000_0000,  1, 1'b0, NO_WORD},
		'{trp_pkg::CMD_EVENT, 14'h3FFF, 8'hFF, 8'hFF, 32'h0000_0000,  1, 1'b0, NO_WORD},
		'{trp_pkg::CMD_EVENT, 14'h2AAA, 8'h55, 8'hAA, 32'hFFFF_FFFF,  1, 1'b0, NO_WORD},
		'{trp_pkg::CMD_EVENT, 14'h1555, 8'hAA, 8'h55, 32'h0000_0000,  1, 1'b0, NO_WORD},
		'{trp_pkg::CMD_EOF,   14'h0000, 8'h00, 8'h00, 32'h1234_5678,  1, 1'b0, NO_WORD},
		// 26 events leave room for exactly the three frame-end elements, so the
		// frame end fills the record and no empty record may follow.
		'{trp_pkg::CMD_EVENT, 14'h0123, 8'h12, 8'h34, 32'h0000_0000, 26, 1'b0, NO_WORD},
		'{trp_pkg::CMD_EOF,   14'h0000, 8'h00, 8'h00, 32'h00AB_CDEF,  1, 1'b0, NO_WORD},
		'{trp_pkg::CMD_EVENT, 14'h3FFF, 8'h00, 8'hFF, 32'h0000_0000, 29, 1'b0, NO_WORD},
		'{trp_pkg::CMD_EVENT, 14'h0A5A, 8'h81, 8'h7E, 32'h0000_0000,  3, 1'b0, NO_WORD},
		'{trp_pkg::CMD_EOF,   14'h0000, 8'h00, 8'h00, 32'h4000_0000,  1, 1'b1, TIME_ERR_WORD},
		'{trp_pkg::CMD_EOF,   14'h0000, 8'h00, 8'h00, 32'h2AAA_AAAA,  1, 1'b0, NO_WORD}
	};

	always @(negedge clk) begin
		out_stall = ($urandom_range(99) < recv_idle_pct);
	end

	always @(posedge clk) begin
		word_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_words.size() == 0) begin
				report_mismatch("unexpected data_word", data_word, 64'h0);
			end else begin
				want = expected_words.pop_front();
				if (data_word !== want.data) begin
					report_mismatch("data_word", data_word, want.data);
				end
				if (last_of_record !== want.last) begin
					report_mismatch("last_of_record", 64'(last_of_record), 64'(want.last));
				end
				if (time_error !== want.err) begin
					report_mismatch("time_error", 64'(time_error), 64'(want.err));
				end
			end
		end
	end

	initial begin
		arst_n     = 1'b0;
		psel       = 1'b0;
		penable    = 1'b0;
		pwrite     = 1'b0;
		paddr      = '0;
		pwdata     = '0;
		in_valid   = 1'b0;
		command    = trp_pkg::CMD_EVENT;
		pha        = '0;
		rawx       = '0;
		rawy       = '0;
		time_ticks = '0;
		out_stall  = 1'b0;
		for (int i = 0; i < RECORD_WORDS; i++) begin
			rec_words[i] = 64'h0;
		end
		fill_level       = HDR_BYTES;
		rec_number       = 8'h00;
		frame_rec_number = 8'h00;
		cfg_header_code  = 8'd31;
		cfg_source_id    = 8'd32;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		send_idle_pct = 8;
		recv_idle_pct = 46;
		for (int i = 0; i < $size(dir_rows); i++) begin
			for (int k = 0; k < dir_rows[i].copies; k++) begin
				send_request(dir_rows[i]);
			end
		end
		settle_block();
		apb_write(trp_pkg::REG_HEADER_CODE, 8'hFF);
		apb_write(trp_pkg::REG_SOURCE_ID, 8'h00);
		run_random_frames(ITEMS_PER_PHASE, 1'b1);

		settle_block();
		send_idle_pct = 46;
		recv_idle_pct = 8;
		apb_write(trp_pkg::REG_HEADER_CODE, 8'h00);
		apb_write(trp_pkg::REG_SOURCE_ID, 8'hFF);
		run_random_frames(ITEMS_PER_PHASE, 1'b0);

		settle_block();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		apb_write(trp_pkg::REG_HEADER_CODE, 8'($urandom));
		apb_write(trp_pkg::REG_SOURCE_ID, 8'($urandom));
		run_random_frames(ITEMS_PER_PHASE, 1'b0);

		settle_block();
		if (mismatch_count == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule
